// File: src/pfx_pkg.sv
// ----------------------------------------------------------------------------
// pfx_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfx_pkg;

    // shift mode of one stack cell
    typedef logic [1:0] t_shift;

    localparam t_shift SH_HOLD = 2'd0;  // keep own entry
    localparam t_shift SH_DOWN = 2'd1;  // take entry from the cell above (push)
    localparam t_shift SH_UP1  = 2'd2;  // take entry from one cell below
    localparam t_shift SH_UP2  = 2'd3;  // take entry from two cells below

    typedef logic [2:0] t_status;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_UNDERFLOW = 3'd1;
    localparam t_status ST_DIVZERO   = 3'd2;
    localparam t_status ST_COUNT     = 3'd3;
    localparam t_status ST_OVERFLOW  = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

endpackage

`default_nettype wire

// File: src/pfx_cell.sv
// ----------------------------------------------------------------------------
// pfx_cell
// One entry of the operand stack; shifts with its neighbors on push and pop.
// ----------------------------------------------------------------------------
`default_nettype none

module pfx_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire pfx_pkg::t_shift        i_shift,
    input  wire logic [VALUE_WIDTH-1:0] i_prev,
    input  wire logic [VALUE_WIDTH-1:0] i_next,
    input  wire logic [VALUE_WIDTH-1:0] i_next2,
    output logic      [VALUE_WIDTH-1:0] o_data
);

    logic [VALUE_WIDTH-1:0] r_data;
    logic [VALUE_WIDTH-1:0] n_data;

    always_comb begin
        case (i_shift)
            pfx_pkg::SH_HOLD: n_data = r_data;
            pfx_pkg::SH_DOWN: n_data = i_prev;
            pfx_pkg::SH_UP1:  n_data = i_next;
            pfx_pkg::SH_UP2:  n_data = i_next2;
            default:          n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// File: src/pfx_alu.sv
// ----------------------------------------------------------------------------
// pfx_alu
// Bit-serial multiplier and signed restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfx_alu #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic                   i_div,
    input  wire logic [VALUE_WIDTH-1:0] i_left,
    input  wire logic [VALUE_WIDTH-1:0] i_right,
    output logic                        o_done,
    output logic      [VALUE_WIDTH-1:0] o_result
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_div;
    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_acc;   // product, or partial remainder
    logic [VALUE_WIDTH-1:0] r_opa;   // multiplicand, or dividend/quotient
    logic [VALUE_WIDTH-1:0] r_opb;   // multiplier, or divisor magnitude

    logic                   w_lneg;
    logic                   w_rneg;
    logic [VALUE_WIDTH-1:0] w_lmag;
    logic [VALUE_WIDTH-1:0] w_rmag;
    logic [VALUE_WIDTH:0]   w_trial;
    logic [VALUE_WIDTH:0]   w_diff;
    logic                   w_qbit;

    assign w_lneg = i_left[VALUE_WIDTH-1];
    assign w_rneg = i_right[VALUE_WIDTH-1];
    assign w_lmag = w_lneg ? (~i_left + 1'b1) : i_left;
    assign w_rmag = w_rneg ? (~i_right + 1'b1) : i_right;

    // restoring step: shift in next dividend bit, subtract when it fits
    assign w_trial = {r_acc, r_opa[VALUE_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_opb};
    assign w_qbit  = !w_diff[VALUE_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(VALUE_WIDTH - 1);
            r_div <= i_div;
            r_neg <= w_lneg ^ w_rneg;
            r_acc <= '0;
            if (i_div) begin
                r_opa <= w_lmag;
                r_opb <= w_rmag;
            end else begin
                r_opa <= i_left;
                r_opb <= i_right;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_div) begin
                r_acc <= w_qbit ? w_diff[VALUE_WIDTH-1:0] : w_trial[VALUE_WIDTH-1:0];
                r_opa <= {r_opa[VALUE_WIDTH-2:0], w_qbit};
            end else begin
                r_acc <= r_acc + (r_opb[0] ? r_opa : '0);
                r_opa <= {r_opa[VALUE_WIDTH-2:0], 1'b0};
                r_opb <= {1'b0, r_opb[VALUE_WIDTH-1:1]};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = !r_div ? r_acc : (r_neg ? (~r_opa + 1'b1) : r_opa);

endmodule

`default_nettype wire

// File: src/postfix_expression_evaluator_core.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Postfix expression evaluator on a shifting stack of cells.
// ----------------------------------------------------------------------------
// Takes one expression character per beat; a digit or '+'/'-' or any ignored
// byte is taken every cycle. '*' and '/' run through a bit-serial unit that
// handles one bit per cycle, and such a beat stalls the input until the
// result is pushed. A '/' by zero, an underflow or an overflow does not stall
// the input. The operand stack is a row of STACK_DEPTH cells with the top at
// cell 0; a push shifts the row down, an operator shifts it up. On the beat
// with last set one result beat comes out with the value and a status; a
// status other than 0 carries value 0. While a result beat waits on a stalled
// output, the input is stalled as well.
`default_nettype none

module postfix_expression_evaluator_core #(
    parameter int STACK_DEPTH = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic signed [31:0] o_value,
    output logic [2:0]       o_status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [VALUE_WIDTH-1:0] w_data [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] w_top_in;
    pfx_pkg::t_shift        w_sh_top;
    pfx_pkg::t_shift        w_sh_rest;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    pfx_pkg::t_status       r_err;
    pfx_pkg::t_status       n_err;
    logic                   r_busy;
    logic                   r_last;
    logic                   r_out_valid;
    logic signed [31:0]     r_value;
    pfx_pkg::t_status       r_status;

    logic                   w_accept;
    logic                   w_finish;
    logic                   w_alu_start;
    logic                   w_alu_div;
    logic                   w_alu_done;
    logic [VALUE_WIDTH-1:0] w_alu_result;
    logic [VALUE_WIDTH-1:0] w_new_top;
    logic [CW-1:0]          w_fin_count;
    pfx_pkg::t_status       w_fin_err;
    logic signed [63:0]     w_ext;

    assign o_in_stall = r_busy || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        logic                   is_digit;
        logic                   is_op;
        logic [VALUE_WIDTH-1:0] digit;
        logic [VALUE_WIDTH-1:0] sum;

        is_digit = i_ch inside {[pfx_pkg::CH_ZERO:pfx_pkg::CH_NINE]};
        is_op    = i_ch inside {pfx_pkg::CH_PLUS, pfx_pkg::CH_MINUS,
                                pfx_pkg::CH_STAR, pfx_pkg::CH_SLASH};
        digit    = VALUE_WIDTH'(i_ch[3:0]);
        sum      = (i_ch == pfx_pkg::CH_MINUS) ? (w_data[1] - w_data[0])
                                               : (w_data[1] + w_data[0]);

        n_count     = r_count;
        n_err       = r_err;
        w_sh_top    = pfx_pkg::SH_HOLD;
        w_sh_rest   = pfx_pkg::SH_HOLD;
        w_top_in    = '0;
        w_new_top   = w_data[0];
        w_alu_start = 1'b0;
        w_alu_div   = (i_ch == pfx_pkg::CH_SLASH);
        w_finish    = 1'b0;

        if (w_accept) begin
            w_finish = i_last;
            if (r_err == pfx_pkg::ST_OK) begin
                if (is_digit) begin
                    if (r_count == CW'(STACK_DEPTH)) begin
                        n_err = pfx_pkg::ST_OVERFLOW;
                    end else begin
                        w_sh_top  = pfx_pkg::SH_DOWN;
                        w_sh_rest = pfx_pkg::SH_DOWN;
                        w_top_in  = digit;
                        w_new_top = digit;
                        n_count   = r_count + 1'b1;
                    end
                end else if (is_op) begin
                    if (r_count < CW'(2)) begin
                        n_err = pfx_pkg::ST_UNDERFLOW;
                    end else if (i_ch == pfx_pkg::CH_PLUS || i_ch == pfx_pkg::CH_MINUS) begin
                        w_sh_top  = pfx_pkg::SH_DOWN;
                        w_sh_rest = pfx_pkg::SH_UP1;
                        w_top_in  = sum;
                        w_new_top = sum;
                        n_count   = r_count - 1'b1;
                    end else if (w_alu_div && w_data[0] == '0) begin
                        // both operands are consumed
                        n_err     = pfx_pkg::ST_DIVZERO;
                        w_sh_top  = pfx_pkg::SH_UP2;
                        w_sh_rest = pfx_pkg::SH_UP2;
                        w_new_top = w_data[2 % STACK_DEPTH];
                        n_count   = r_count - CW'(2);
                    end else begin
                        // result beat waits for the serial unit
                        w_alu_start = 1'b1;
                        w_finish    = 1'b0;
                    end
                end
            end
        end

        if (w_alu_done) begin
            w_sh_top  = pfx_pkg::SH_DOWN;
            w_sh_rest = pfx_pkg::SH_UP1;
            w_top_in  = w_alu_result;
            w_new_top = w_alu_result;
            n_count   = r_count - 1'b1;
            w_finish  = r_last;
        end

        w_fin_count = n_count;
        w_fin_err   = n_err;
        if (w_finish) begin
            n_count = '0;
            n_err   = pfx_pkg::ST_OK;
        end
    end

    assign w_ext = 64'(signed'(w_new_top));

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            logic [VALUE_WIDTH-1:0] w_prev;
            logic [VALUE_WIDTH-1:0] w_next;
            logic [VALUE_WIDTH-1:0] w_next2;

            if (gi == 0) begin : g_first
                assign w_prev = w_top_in;
            end else begin : g_mid
                assign w_prev = w_data[gi-1];
            end
            if (gi + 1 < STACK_DEPTH) begin : g_n1
                assign w_next = w_data[gi+1];
            end else begin : g_n1_end
                assign w_next = '0;
            end
            if (gi + 2 < STACK_DEPTH) begin : g_n2
                assign w_next2 = w_data[gi+2];
            end else begin : g_n2_end
                assign w_next2 = '0;
            end

            pfx_cell #(
                .VALUE_WIDTH(VALUE_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_shift ((gi == 0) ? w_sh_top : w_sh_rest),
                .i_prev  (w_prev),
                .i_next  (w_next),
                .i_next2 (w_next2),
                .o_data  (w_data[gi])
            );
        end
    endgenerate

    pfx_alu #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_alu_start),
        .i_div    (w_alu_div),
        .i_left   (w_data[1]),
        .i_right  (w_data[0]),
        .o_done   (w_alu_done),
        .o_result (w_alu_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= pfx_pkg::ST_OK;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_err   <= n_err;
            if (w_alu_start) begin
                r_busy <= 1'b1;
            end else if (w_alu_done) begin
                r_busy <= 1'b0;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_alu_start) begin
            r_last <= i_last;
        end
        if (w_finish) begin
            if (w_fin_err != pfx_pkg::ST_OK) begin
                r_value  <= '0;
                r_status <= w_fin_err;
            end else if (w_fin_count == CW'(1)) begin
                r_value  <= w_ext[31:0];
                r_status <= pfx_pkg::ST_OK;
            end else begin
                r_value  <= '0;
                r_status <= pfx_pkg::ST_COUNT;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;

    // error beats never carry a value
    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != pfx_pkg::ST_OK |-> o_value == '0)
        else $error("error result with nonzero value");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // serial unit only finishes an operation that was started
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_done |-> r_busy)
        else $error("serial unit done while idle");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= pfx_pkg::ST_OVERFLOW)
        else $error("status code out of range");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the postfix expression evaluator core.
// ----------------------------------------------------------------------------
// Character beats are queued up front and played out by a clocked driver with
// random gaps; a clocked monitor stalls at random and checks every result beat
// against an in-bench stack calculator. Directed expressions cover the edge
// cases, then random well-formed, broken, overflow and noise expressions follow.
`default_nettype none

module tb_top;

    localparam int STACK_CELLS = 32;
    localparam int COUNTED_BEATS = 1050;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 60;

    typedef struct {
        logic [7:0]  ch;
        logic        last;
        int unsigned gap;
        bit          drain;
        bit          squeeze;
    } t_char_beat;

    typedef struct {
        logic signed [31:0] value;
        pfx_pkg::t_status   status;
    } t_eval_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [7:0]         i_ch = 8'h00;
    logic               i_last = 1'b0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [31:0] o_value;
    logic [2:0]         o_status;

    t_char_beat   char_q[$];
    t_eval_result pending_results[$];

    // bench copy of the evaluator state
    logic [31:0]      expr_stack [STACK_CELLS];
    int unsigned      expr_depth = 0;
    pfx_pkg::t_status expr_err = pfx_pkg::ST_OK;

    int unsigned mismatch_cnt = 0;
    int unsigned counted_beats = 0;
    bit          tx_quiet = 1'b0;
    bit          mark_drain = 1'b0;
    bit          mark_squeeze = 1'b0;
    logic        squeeze_req = 1'b0;

    postfix_expression_evaluator_core #(
        .STACK_DEPTH(STACK_CELLS),
        .VALUE_WIDTH(32)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value),
        .o_status    (o_status)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic bit is_operator(input logic [7:0] c);
        return c inside {pfx_pkg::CH_PLUS, pfx_pkg::CH_MINUS,
                         pfx_pkg::CH_STAR, pfx_pkg::CH_SLASH};
    endfunction

    function automatic bit is_active(input logic [7:0] c);
        return (c inside {[pfx_pkg::CH_ZERO:pfx_pkg::CH_NINE]}) || is_operator(c);
    endfunction

    function automatic logic [7:0] idle_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (is_active(b));
        return b;
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 3))
            0: return pfx_pkg::CH_PLUS;
            1: return pfx_pkg::CH_MINUS;
            2: return pfx_pkg::CH_STAR;
            default: return pfx_pkg::CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return pfx_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // one character step of the calculator, queues a result on the last beat
    task automatic eval_char(input logic [7:0] c, input logic fin);
        logic [31:0]  lhs, rhs, res, mag_l, mag_r;
        bit           by_zero;
        t_eval_result r;
        by_zero = 1'b0;
        res = '0;
        if (expr_err == pfx_pkg::ST_OK) begin
            if (c inside {[pfx_pkg::CH_ZERO:pfx_pkg::CH_NINE]}) begin
                if (expr_depth >= STACK_CELLS) begin
                    expr_err = pfx_pkg::ST_OVERFLOW;
                end else begin
                    expr_stack[expr_depth] = 32'(c - pfx_pkg::CH_ZERO);
                    expr_depth++;
                end
            end else if (is_operator(c)) begin
                if (expr_depth < 2) begin
                    expr_err = pfx_pkg::ST_UNDERFLOW;
                end else begin
                    rhs = expr_stack[expr_depth - 1];
                    lhs = expr_stack[expr_depth - 2];
                    expr_depth -= 2;
                    case (c)
                        pfx_pkg::CH_PLUS:  res = lhs + rhs;
                        pfx_pkg::CH_MINUS: res = lhs - rhs;
                        pfx_pkg::CH_STAR:  res = lhs * rhs;
                        default: begin
                            if (rhs == '0) begin
                                by_zero = 1'b1;
                            end else begin
                                // truncate toward zero on magnitudes
                                mag_l = lhs[31] ? -lhs : lhs;
                                mag_r = rhs[31] ? -rhs : rhs;
                                res = mag_l / mag_r;
                                if (lhs[31] != rhs[31]) res = -res;
                            end
                        end
                    endcase
                    if (by_zero) begin
                        expr_err = pfx_pkg::ST_DIVZERO;
                    end else begin
                        expr_stack[expr_depth] = res;
                        expr_depth++;
                    end
                end
            end
        end
        if (fin) begin
            r.value = '0;
            if (expr_err != pfx_pkg::ST_OK) begin
                r.status = expr_err;
            end else if (expr_depth == 1) begin
                r.value = $signed(expr_stack[0]);
                r.status = pfx_pkg::ST_OK;
            end else begin
                r.status = pfx_pkg::ST_COUNT;
            end
            pending_results = {pending_results, r};
            expr_depth = 0;
            expr_err = pfx_pkg::ST_OK;
        end
    endtask

    // ---------------- stimulus building ----------------

    task automatic put_char(input logic [7:0] c, input logic fin);
        t_char_beat b;
        b.ch = c;
        b.last = fin;
        b.gap = tx_quiet ? 0 : $urandom_range(0, 11);
        b.drain = mark_drain;
        b.squeeze = mark_squeeze;
        mark_drain = 1'b0;
        mark_squeeze = 1'b0;
        char_q = {char_q, b};
        counted_beats++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_char(s[i], i == s.len() - 1);
        end
    endtask

    // random expression that balances to one value, n operands
    task automatic put_wellformed(input int unsigned n);
        int unsigned pushed, depth;
        logic [7:0]  c;
        pushed = 0;
        depth = 0;
        while (pushed < n || depth > 1) begin
            if (depth < 2 || (pushed < n && $urandom_range(0, 1) == 1)) begin
                c = pick_digit();
                pushed++;
                depth++;
            end else begin
                c = pick_operator();
                depth--;
            end
            if ($urandom_range(0, 15) == 0) put_char(idle_byte(), 1'b0);
            put_char(c, pushed == n && depth == 1);
        end
    endtask

    // digits, operators and idle bytes in any order, often unbalanced
    task automatic put_broken();
        int unsigned len;
        len = $urandom_range(1, 10);
        for (int unsigned i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
                0, 1: put_char(pick_digit(), i == len - 1);
                2:    put_char(pick_operator(), i == len - 1);
                default: put_char(idle_byte(), i == len - 1);
            endcase
        end
    endtask

    task automatic put_overflow();
        int unsigned len;
        len = $urandom_range(STACK_CELLS + 1, STACK_CELLS + 3);
        for (int unsigned i = 0; i < len; i++) put_char(pick_digit(), 1'b0);
        put_char(pick_operator(), 1'b0);
        put_char(pick_digit(), 1'b1);
    endtask

    task automatic put_noise();
        int unsigned len;
        len = $urandom_range(1, 6);
        for (int unsigned i = 0; i < len; i++) begin
            put_char(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    task automatic build_directed();
        string s;
        put_char(8'h00, 1'b1);          // empty expression
        put_char(8'hFF, 1'b1);
        put_text("9");
        put_text("0");
        put_text("34+");
        put_text("34-");
        put_text("34*");
        put_text("73/");
        put_text("07-3/");              // negative quotient truncates
        put_text("+");                  // underflow on empty stack
        put_text("5/");
        put_text("50/");                // divide by zero
        put_text("50/12+*3");           // frozen after an error
        put_text("12");                 // two left at the end
        put_char(pfx_pkg::CH_SLASH - 8'd1, 1'b0);
        put_char(pfx_pkg::CH_NINE + 8'd1, 1'b0);
        put_char(pfx_pkg::CH_SLASH, 1'b0);
        put_text("5 9:*.");
        s = "";
        repeat (STACK_CELLS) s = {s, "9"};
        repeat (STACK_CELLS - 1) s = {s, "+"};
        put_text(s);                    // stack exactly full, then folded
        s = "";
        repeat (STACK_CELLS + 1) s = {s, "7"};
        put_text({s, "+"});             // overflow
        s = "8";
        repeat (9) s = {s, "8*"};
        put_text({s, "2*01-/"});        // most negative over minus one
        s = "9";
        repeat (12) s = {s, "9*"};
        put_text({s, "09-*"});          // wrapping product
        put_char(8'hFF, 1'b0);
        put_text("4");
    endtask

    task automatic build_random();
        int unsigned expr_idx;
        expr_idx = 0;
        while (counted_beats < COUNTED_BEATS) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            if (expr_idx % 150 == 75) mark_drain = 1'b1;
            if (expr_idx == 200) begin
                // receiver holds off while the sender keeps pushing
                mark_squeeze = 1'b1;
                tx_quiet = 1'b1;
                repeat (40) put_text("34+");
            end
            case ($urandom_range(0, 19))
                0, 1:  put_broken();
                2:     put_noise();
                3:     put_overflow();
                4:     put_wellformed($urandom_range(20, STACK_CELLS));
                default: put_wellformed($urandom_range(1, 8));
            endcase
            expr_idx++;
        end
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin : char_driver
        logic        offer;
        t_char_beat  nxt;
        bit          gap_armed;
        int unsigned gap_left;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_ch <= 8'h00;
            i_last <= 1'b0;
            squeeze_req <= 1'b0;
            gap_armed = 1'b0;
            gap_left = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                eval_char(i_ch, i_last);
            end
            if (!i_in_valid || !o_in_stall) begin
                offer = 1'b0;
                if (char_q.size() != 0) begin
                    if (!gap_armed) begin
                        gap_left = char_q[0].gap;
                        gap_armed = 1'b1;
                    end
                    if (gap_left != 0) begin
                        gap_left--;
                    end else if (!(char_q[0].drain && pending_results.size() != 0)) begin
                        nxt = char_q.pop_front();
                        i_ch <= nxt.ch;
                        i_last <= nxt.last;
                        if (nxt.squeeze) squeeze_req <= 1'b1;
                        gap_armed = 1'b0;
                        offer = 1'b1;
                    end
                end
                i_in_valid <= offer;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin : result_monitor
        logic         hold;
        t_eval_result want;
        int unsigned  stall_left;
        int unsigned  hold_left;
        int unsigned  results_seen;
        bit           hold_done;
        bit           rx_quiet;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            results_seen = 0;
            hold_done = 1'b0;
            rx_quiet = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat value %0d status %0d",
                                              o_value, o_status));
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  o_status, want.status));
                    end
                    if (o_value !== want.value) begin
                        report_mismatch($sformatf("value %0d, want %0d",
                                                  o_value, want.value));
                    end
                end
                results_seen++;
                if (results_seen % 40 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
                stall_left = rx_quiet ? 0 : $urandom_range(0, 11);
            end
            if (hold_left != 0) begin
                hold_left--;
                hold = 1'b1;
            end else if (squeeze_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                hold = 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                hold = 1'b1;
            end else begin
                hold = 1'b0;
            end
            i_out_stall <= hold;
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge i_clk) begin : idle_watchdog
        int unsigned idle_cycles;
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        build_directed();
        build_random();
        tx_quiet = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (char_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
